@@ src/nbsd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the navigation bit sync demodulator.
// Depends on nothing; every other file imports it.
package nbsd_pkg;

    localparam int NUM_CHANNELS    = 32;
    localparam int BITS_PER_SYMBOL = 20;
    localparam int CH_W            = 5;
    localparam int TS_W            = 48;
    localparam int CNT_W           = 5;
    localparam int ADDR_W          = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RANGE_W         = 7;

    localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(BITS_PER_SYMBOL - 1);

    localparam logic [1:0] PHASE_WAIT_FIRST = 2'd0;
    localparam logic [1:0] PHASE_WAIT_EDGE  = 2'd1;
    localparam logic [1:0] PHASE_START      = 2'd2;
    localparam logic [1:0] PHASE_COLLECT    = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0] channel_index;
        logic            pll_bit;
        logic [TS_W-1:0] bit_timestamp;
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0] out_channel;
        logic            data_bit;
        logic [TS_W-1:0] start_timestamp;
        logic            sync_error;
    } result_t;

    typedef struct packed {
        logic [1:0]                 sync_phase;
        logic [BITS_PER_SYMBOL-1:0] bit_history;
        logic [TS_W-1:0]            group_start_time;
        logic [CNT_W-1:0]           bit_count;
    } chan_state_t;

    typedef struct packed {
        logic        wr_en;
        chan_state_t next_state;
        logic        emit;
        result_t     res;
    } update_t;

endpackage

@@ src/nbsd_state_table.sv @@
`timescale 1ns / 1ps
// Per-channel sync state, one entry per channel, with one read and one write port.
// Depends on nbsd_pkg.
module nbsd_state_table
    import nbsd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] rd_addr,
    output chan_state_t       rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  chan_state_t       wr_data
);

    logic [NUM_CHANNELS-1:0] valid_reg;
    chan_state_t             entry_reg [NUM_CHANNELS];

    // An entry never written since reset reads as all zero.
    assign rd_data = valid_reg[rd_addr] ? entry_reg[rd_addr] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_addr] <= wr_data;
        end
    end

endmodule

@@ src/nbsd_update.sv @@
`timescale 1ns / 1ps
// Next-state and result logic of the per-channel bit sync machine.
// Depends on nbsd_pkg.
module nbsd_update
    import nbsd_pkg::*;
(
    input  item_t       item,
    input  chan_state_t cur,
    output update_t     upd
);

    logic [BITS_PER_SYMBOL-1:0] hist;
    logic [CNT_W-1:0]           cnt_inc;
    logic                       in_range;
    logic                       all_same;
    chan_state_t                group_begin;

    assign hist     = {cur.bit_history[BITS_PER_SYMBOL-2:0], item.pll_bit};
    assign cnt_inc  = cur.bit_count + CNT_W'(1);
    assign in_range = {{(RANGE_W-CH_W){1'b0}}, item.channel_index} < RANGE_W'(NUM_CHANNELS);
    assign all_same = (hist == '0) || (hist == '1);

    // The bit that opens a group becomes its only history bit.
    always_comb
    begin
        group_begin                  = cur;
        group_begin.bit_history      = BITS_PER_SYMBOL'(item.pll_bit);
        group_begin.group_start_time = item.bit_timestamp;
        group_begin.bit_count        = '0;
        group_begin.sync_phase       = PHASE_COLLECT;
    end

    always_comb
    begin
        upd                     = '0;
        upd.wr_en               = in_range;
        upd.next_state          = cur;
        upd.res.out_channel     = item.channel_index;
        upd.res.start_timestamp = cur.group_start_time;
        case (cur.sync_phase)
            PHASE_WAIT_FIRST:
            begin
                upd.next_state.bit_history = BITS_PER_SYMBOL'(item.pll_bit);
                upd.next_state.sync_phase  = PHASE_WAIT_EDGE;
            end
            PHASE_WAIT_EDGE:
            begin
                if (hist[1] != hist[0])
                begin
                    upd.next_state = group_begin;
                end
                else
                begin
                    upd.next_state.bit_history = hist;
                end
            end
            PHASE_START:
            begin
                upd.next_state = group_begin;
            end
            default:
            begin
                upd.next_state.bit_history = hist;
                upd.next_state.bit_count   = cnt_inc;
                if (cnt_inc == LAST_COUNT)
                begin
                    upd.emit = in_range;
                    if (all_same)
                    begin
                        upd.res.data_bit          = hist[0];
                        upd.next_state.sync_phase = PHASE_START;
                    end
                    else
                    begin
                        upd.res.sync_error        = 1'b1;
                        upd.next_state.sync_phase = PHASE_WAIT_FIRST;
                    end
                end
            end
        endcase
    end

endmodule

@@ src/nav_bit_sync_demodulator.sv @@
`timescale 1ns / 1ps
// Navigation bit sync demodulator: 20-bit group sync per channel on a word stream.
// Each word passes the input register, then its result goes to the result register.
// Throughput: one input word per cycle unless result_stall holds the pipeline.
// Reset clears the pipeline valids and marks every channel state as all zero.
// Depends on nbsd_pkg, nbsd_state_table and nbsd_update.
module nav_bit_sync_demodulator
    import nbsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    item_t       s1_item_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_reg;
    logic        advance;
    logic        s1_load;
    chan_state_t cur_state;
    update_t     upd;

    // The input stage moves on whenever the result register is free or being taken.
    assign advance    = !out_valid_reg || !result_stall;
    // The input register takes a new word whenever it is empty or its word moves on.
    assign s1_load    = !s1_valid_reg || advance;
    assign item_stall = !s1_load;

    nbsd_state_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (s1_item_reg.channel_index[ADDR_W-1:0]),
        .rd_data (cur_state),
        .wr_en   (s1_valid_reg && advance && upd.wr_en),
        .wr_addr (s1_item_reg.channel_index[ADDR_W-1:0]),
        .wr_data (upd.next_state)
    );

    nbsd_update u_update (
        .item (s1_item_reg),
        .cur  (cur_state),
        .upd  (upd)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = item_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = s1_valid_reg && upd.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_item_reg <= item;
        end
        if (advance)
        begin
            out_reg <= upd.res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

`ifndef ASSERT_OFF
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && out_valid_reg && result_stall))
        else $error("input stalled while the pipeline could move");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.sync_error && result.data_bit))
        else $error("error word carries a data bit");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance && upd.emit) |=> result_valid)
        else $error("finished group produced no result word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && advance && upd.emit) |-> (cur_state.sync_phase == PHASE_COLLECT))
        else $error("result word outside the collecting phase");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for nav_bit_sync_demodulator: directed table, then random bit streams.
// Depends on nbsd_pkg and the RTL of the block; it predicts each result word on its own.
module tb;
    import nbsd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 750;

    typedef struct {
        item_t   word;
        int      count;
        bit      typed;
        result_t want;
    } dir_row_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Per-channel sync state as the block should hold it.
    logic [1:0]                 chan_phase    [NUM_CHANNELS];
    logic [BITS_PER_SYMBOL-1:0] chan_hist     [NUM_CHANNELS];
    logic [TS_W-1:0]            chan_group_ts [NUM_CHANNELS];
    logic [CNT_W-1:0]           chan_count    [NUM_CHANNELS];

    result_t  expected_bits [$];
    dir_row_t dir_rows [$];
    result_t  want_res;
    int       mismatches = 0;
    int       cycles = 0;
    bit       calm = 1'b0;

    nav_bit_sync_demodulator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_stall <= !calm && ($urandom_range(99) < 15);
    end

    task automatic start_group(input int ch, input item_t w);
        chan_hist[ch]     = BITS_PER_SYMBOL'(w.pll_bit);
        chan_group_ts[ch] = w.bit_timestamp;
        chan_count[ch]    = '0;
        chan_phase[ch]    = PHASE_COLLECT;
    endtask

    task automatic bit_sync_predict(input item_t w, output bit hit, output result_t r);
        logic [BITS_PER_SYMBOL-1:0] h;
        int ch;
        hit = 1'b0;
        r = '0;
        ch = int'(w.channel_index);
        if (ch >= NUM_CHANNELS)
            return;
        h = {chan_hist[ch][BITS_PER_SYMBOL-2:0], w.pll_bit};
        case (chan_phase[ch])
            PHASE_WAIT_FIRST:
            begin
                chan_hist[ch]  = BITS_PER_SYMBOL'(w.pll_bit);
                chan_phase[ch] = PHASE_WAIT_EDGE;
            end
            PHASE_WAIT_EDGE:
            begin
                chan_hist[ch] = h;
                // The bit that breaks the run becomes the first bit of the group.
                if (h[1] != h[0])
                    start_group(ch, w);
            end
            PHASE_START:
                start_group(ch, w);
            default:
            begin
                chan_hist[ch]  = h;
                chan_count[ch] = chan_count[ch] + CNT_W'(1);
                if (chan_count[ch] == LAST_COUNT)
                begin
                    hit = 1'b1;
                    r.out_channel     = w.channel_index;
                    r.start_timestamp = chan_group_ts[ch];
                    if (h == '0 || h == '1)
                    begin
                        r.data_bit     = h[0];
                        r.sync_error   = 1'b0;
                        chan_phase[ch] = PHASE_START;
                    end
                    else
                    begin
                        r.data_bit     = 1'b0;
                        r.sync_error   = 1'b1;
                        chan_phase[ch] = PHASE_WAIT_FIRST;
                    end
                end
            end
        endcase
    endtask

    // Called at a falling edge; returns at a falling edge after the word is taken.
    task automatic send_word(input item_t w, input bit use_typed, input result_t typed_res);
        bit      hit;
        result_t r;
        item       <= w;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        bit_sync_predict(w, hit, r);
        if (use_typed)
            expected_bits.push_back(typed_res);
        else if (hit)
            expected_bits.push_back(r);
        @(negedge clk);
        if (!calm && $urandom_range(99) < 6)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4))
                @(negedge clk);
        end
    endtask

    task automatic add_row(input logic [CH_W-1:0] ch, input logic b, input logic [TS_W-1:0] ts,
                           input int n, input bit typed, input result_t want);
        dir_row_t row;
        row.word.channel_index = ch;
        row.word.pll_bit       = b;
        row.word.bit_timestamp = ts;
        row.count = n;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_bits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: ch %0d bit %0d ts %h err %0d",
                             result.out_channel, result.data_bit, result.start_timestamp,
                             result.sync_error);
            end
            else
            begin
                want_res = expected_bits.pop_front();
                if (result.out_channel !== want_res.out_channel
                    || result.data_bit !== want_res.data_bit
                    || result.start_timestamp !== want_res.start_timestamp
                    || result.sync_error !== want_res.sync_error)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected ch %0d bit %0d ts %h err %0d,",
                                  " got ch %0d bit %0d ts %h err %0d"},
                                 want_res.out_channel, want_res.data_bit,
                                 want_res.start_timestamp, want_res.sync_error,
                                 result.out_channel, result.data_bit,
                                 result.start_timestamp, result.sync_error);
                end
            end
        end
    end

    initial
    begin
        item_t       w;
        logic [4:0]  pool_base;
        logic [CH_W-1:0] ch;
        int          n;

        foreach (chan_phase[i])
        begin
            chan_phase[i]    = PHASE_WAIT_FIRST;
            chan_hist[i]     = '0;
            chan_group_ts[i] = '0;
            chan_count[i]    = '0;
        end

        // First bit, a repeated bit, then the transition that opens an all-ones group
        // stamped with the largest time tag.
        add_row(5'd31, 1'b0, 48'h5555_5555_5555, 1, 1'b0, '0);
        add_row(5'd31, 1'b0, 48'h0000_0000_0010, 1, 1'b0, '0);
        add_row(5'd31, 1'b1, 48'hFFFF_FFFF_FFFF, 1, 1'b0, '0);
        add_row(5'd31, 1'b1, 48'h0000_0000_0100, 19, 1'b1,
                result_t'({5'd31, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b0}));
        // A group that disagrees in its last bit reports an error and drops sync.
        add_row(5'd0, 1'b1, 48'hAAAA_AAAA_AAAA, 1, 1'b0, '0);
        add_row(5'd0, 1'b0, 48'h0000_0000_0000, 1, 1'b0, '0);
        add_row(5'd0, 1'b0, 48'h0000_0000_0001, 18, 1'b0, '0);
        add_row(5'd0, 1'b1, 48'h0000_0000_0020, 1, 1'b1,
                result_t'({5'd0, 1'b0, 48'h0000_0000_0000, 1'b1}));

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
        begin
            for (int i = 0; i < dir_rows[r].count; i++)
            begin
                w = dir_rows[r].word;
                w.bit_timestamp = dir_rows[r].word.bit_timestamp + TS_W'(i);
                send_word(w, dir_rows[r].typed && i == dir_rows[r].count - 1, dir_rows[r].want);
            end
        end

        // Random part: mostly well-formed streams on a few busy channels, some noise.
        n = 0;
        pool_base = 5'($urandom_range(31));
        while (n < RANDOM_WORDS)
        begin
            calm = (n >= 300 && n < 420);
            if (n % 150 == 0)
                pool_base = 5'($urandom_range(31));
            if ($urandom_range(99) < 10)
            begin
                w.channel_index = CH_W'($urandom);
                w.pll_bit       = 1'($urandom);
            end
            else
            begin
                ch = CH_W'(pool_base + $urandom_range(3));
                w.channel_index = ch;
                case (chan_phase[ch])
                    PHASE_WAIT_EDGE:
                        w.pll_bit = ($urandom_range(99) < 70) ? ~chan_hist[ch][0]
                                                              : chan_hist[ch][0];
                    PHASE_COLLECT:
                        w.pll_bit = ($urandom_range(999) < 985) ? chan_hist[ch][0]
                                                                : ~chan_hist[ch][0];
                    default:
                        w.pll_bit = 1'($urandom);
                endcase
            end
            w.bit_timestamp = TS_W'({$urandom, $urandom});
            send_word(w, 1'b0, '0);
            n++;
        end
        calm = 1'b0;
        item_valid <= 1'b0;

        while (expected_bits.size() != 0)
            @(posedge clk);
        repeat (10)
            @(posedge clk);

        if (mismatches == 0 && expected_bits.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ nav_bit_sync_demodulator.f @@
src/nbsd_pkg.sv
src/nbsd_state_table.sv
src/nbsd_update.sv
src/nav_bit_sync_demodulator.sv
sim/tb.sv
